// ===== hw/rtl/srp_pkg.sv =====
// Shared types and constants for the shelf rectangle packer.
// Used by srp_cell, shelf_rectangle_packer and srp_checker; no dependencies.
`default_nettype none

package srp_pkg;

  localparam int unsigned MAX_SHELVES_DEF = 64;

  localparam int unsigned WW = 13;  // width field
  localparam int unsigned HW = 16;  // height / y field
  localparam int unsigned XW = 12;  // reported x position

  localparam logic [WW-1:0] ATLAS_WIDTH_RST  = 13'd1024;
  localparam logic [HW-1:0] ATLAS_HEIGHT_RST = 16'd0;

  localparam logic REG_ATLAS_WIDTH  = 1'b0;
  localparam logic REG_ATLAS_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_PLACED     = 2'd0,
    ST_NO_ROOM    = 2'd1,
    ST_TABLE_FULL = 2'd2
  } status_e;

  // search token passed from cell to cell
  typedef struct packed {
    logic          active;  // token present in this stage
    logic          done;    // a cell has answered the request
    logic          opened;  // answer opened a new shelf
    status_e       status;
    logic [WW-1:0] x;
    logic [HW-1:0] y;
    logic [HW:0]   bottom;  // bottom of the last shelf passed
  } tok_t;

endpackage

`default_nettype wire

// ===== hw/rtl/srp_cell.sv =====
// One shelf slot of the packer chain: holds top, used width and height of a shelf.
// Examines the search token, answers or forwards it. Depends on srp_pkg.
`default_nettype none

module srp_cell #(
  parameter int unsigned MaxShelves = srp_pkg::MAX_SHELVES_DEF,
  parameter int unsigned Idx        = 0
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire [$clog2(MaxShelves+1)-1:0]     count_i,
  input  wire [srp_pkg::WW-1:0]              atlas_width_i,
  input  wire [srp_pkg::HW-1:0]              atlas_height_i,
  input  wire [srp_pkg::WW-1:0]              req_width_i,
  input  wire [srp_pkg::HW-1:0]              req_height_i,
  input  srp_pkg::tok_t                      tok_i,
  output srp_pkg::tok_t                      tok_o
);
  import srp_pkg::*;

  localparam int unsigned CntW = $clog2(MaxShelves + 1);

  logic [HW-1:0] top_q, top_d;
  logic [WW-1:0] used_q, used_d;
  logic [HW-1:0] hgt_q, hgt_d;
  tok_t          tok_q, tok_d;

  logic          occupied, last;
  logic [WW-1:0] room;
  logic          fit_x, fit_h, grow_ok, open_ok;

  assign occupied = count_i > CntW'(Idx);
  assign last     = count_i == CntW'(Idx + 1);
  assign room     = (used_q > atlas_width_i) ? '0 : atlas_width_i - used_q;
  assign fit_x    = room >= req_width_i;
  assign fit_h    = hgt_q >= req_height_i;
  assign grow_ok  = last && (top_q <= atlas_height_i)
                    && ((atlas_height_i - top_q) >= req_height_i);
  assign open_ok  = (tok_i.bottom <= {1'b0, atlas_height_i})
                    && ({1'b0, req_height_i} <= ({1'b0, atlas_height_i} - tok_i.bottom));

  always_comb begin
    tok_d  = tok_i;
    top_d  = top_q;
    used_d = used_q;
    hgt_d  = hgt_q;
    if (tok_i.active && !tok_i.done) begin
      if (occupied) begin
        if (fit_x && (fit_h || grow_ok)) begin
          tok_d.done   = 1'b1;
          tok_d.status = ST_PLACED;
          tok_d.x      = used_q;
          tok_d.y      = top_q;
          used_d       = used_q + req_width_i;
          if (!fit_h) begin
            hgt_d = req_height_i;
          end
        end else begin
          tok_d.bottom = {1'b0, top_q} + {1'b0, hgt_q};
        end
      end else begin
        tok_d.done = 1'b1;
        if (open_ok) begin
          tok_d.status = ST_PLACED;
          tok_d.opened = 1'b1;
          tok_d.x      = '0;
          tok_d.y      = tok_i.bottom[HW-1:0];
          top_d        = tok_i.bottom[HW-1:0];
          used_d       = req_width_i;
          hgt_d        = req_height_i;
        end else begin
          tok_d.status = ST_NO_ROOM;
          tok_d.x      = '0;
          tok_d.y      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    used_q <= used_d;
    hgt_q  <= hgt_d;
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// ===== hw/rtl/shelf_rectangle_packer.sv =====
// Shelf rectangle packer: first-fit shelf placement of rectangles in a 2-D atlas.
// Top level: request/result channels, configuration registers, chain of srp_cell.
// Depends on srp_pkg and srp_cell.
//
// Usage:
//   Requests (req_width_i, req_height_i) transfer on in_valid_i/in_ready_o; each
//   gives one result (status_o, place_x_o, place_y_o) on out_valid_o/out_ready_i.
//   One request is in work at a time. An accepted request injects a token into a
//   chain of MaxShelves cells, one cell per cycle; the finished result is registered
//   in a pending register and then moves into the output register. An oversize
//   request skips the chain and goes straight to the pending register.
//   in_ready_o drops while the token walks and while a finished result waits to
//   move into the output register. A stalled receiver holds the result; the next
//   request may be taken and walked while the previous result is still waiting.
//   Configuration: cfg_we_i writes atlas width (index 0) or atlas height (index 1)
//   from cfg_wdata_i; write only while idle.
//   Reset: atlas width 1024, atlas height 0, shelf table empty, no result pending.
`default_nettype none

module shelf_rectangle_packer #(
  parameter int unsigned MaxShelves = srp_pkg::MAX_SHELVES_DEF
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire [srp_pkg::WW-1:0]    req_width_i,
  input  wire [srp_pkg::HW-1:0]    req_height_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output logic [1:0]               status_o,
  output logic [srp_pkg::XW-1:0]   place_x_o,
  output logic [srp_pkg::HW-1:0]   place_y_o,
  input  wire                      cfg_we_i,
  input  wire                      cfg_idx_i,
  input  wire [srp_pkg::HW-1:0]    cfg_wdata_i
);
  import srp_pkg::*;

  localparam int unsigned CntW = $clog2(MaxShelves + 1);

  logic [WW-1:0]   aw_q;
  logic [HW-1:0]   ah_q;
  logic [CntW-1:0] count_q;
  logic [WW-1:0]   w_q;
  logic [HW-1:0]   h_q;
  logic            busy_q, pend_valid_q, out_valid_q;
  status_e         pend_st_q, out_st_q;
  logic [XW-1:0]   pend_x_q, out_x_q;
  logic [HW-1:0]   pend_y_q, out_y_q;
  tok_t            inj_q;
  tok_t            tok [MaxShelves+1];
  tok_t            tok_end;

  logic in_xfer, oversize, pend_move;

  assign in_ready_o = !busy_q && !pend_valid_q;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign oversize   = (req_width_i > aw_q) || (req_height_i > ah_q);
  assign pend_move  = pend_valid_q && (!out_valid_q || out_ready_i);
  assign tok_end    = tok[MaxShelves];
  assign tok[0]     = inj_q;

  for (genvar i = 0; i < MaxShelves; i++) begin : g_cell
    srp_cell #(
      .MaxShelves(MaxShelves),
      .Idx       (i)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .count_i       (count_q),
      .atlas_width_i (aw_q),
      .atlas_height_i(ah_q),
      .req_width_i   (w_q),
      .req_height_i  (h_q),
      .tok_i         (tok[i]),
      .tok_o         (tok[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q         <= ATLAS_WIDTH_RST;
      ah_q         <= ATLAS_HEIGHT_RST;
      count_q      <= '0;
      busy_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      inj_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ATLAS_WIDTH:  aw_q <= cfg_wdata_i[WW-1:0];
          REG_ATLAS_HEIGHT: ah_q <= cfg_wdata_i;
          default:          ;
        endcase
      end
      inj_q.active <= in_xfer && !oversize;
      if (pend_move) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= 1'b0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_xfer) begin
        if (oversize) begin
          pend_valid_q <= 1'b1;
        end else begin
          busy_q       <= 1'b1;
        end
      end
      if (tok_end.active) begin
        busy_q       <= 1'b0;
        pend_valid_q <= 1'b1;
        if (tok_end.done && tok_end.opened) begin
          count_q <= count_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      w_q <= req_width_i;
      h_q <= req_height_i;
      if (oversize) begin
        pend_st_q <= ST_NO_ROOM;
        pend_x_q  <= '0;
        pend_y_q  <= '0;
      end
    end
    if (tok_end.active) begin
      if (tok_end.done) begin
        pend_st_q <= tok_end.status;
        pend_x_q  <= tok_end.x[XW-1:0];
        pend_y_q  <= tok_end.y;
      end else begin
        pend_st_q <= ST_TABLE_FULL;
        pend_x_q  <= '0;
        pend_y_q  <= '0;
      end
    end
    if (pend_move) begin
      out_st_q <= pend_st_q;
      out_x_q  <= pend_x_q;
      out_y_q  <= pend_y_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_st_q;
  assign place_x_o   = out_x_q;
  assign place_y_o   = out_y_q;

endmodule

`default_nettype wire

// ===== hw/rtl/srp_checker.sv =====
// Port-level checks for shelf_rectangle_packer, attached by bind.
// Depends on srp_pkg and the top level's port names.
`default_nettype none

module srp_checker (
  input wire                    clk_i,
  input wire                    rst_ni,
  input wire                    in_valid_i,
  input wire                    in_ready_o,
  input wire                    out_valid_o,
  input wire                    out_ready_i,
  input wire [1:0]              status_o,
  input wire [srp_pkg::XW-1:0]  place_x_o,
  input wire [srp_pkg::HW-1:0]  place_y_o
);
  import srp_pkg::*;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(place_x_o) && $stable(place_y_o))
    else $error("result changed under stall");

  // failures report a zero position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_PLACED |-> place_x_o == '0 && place_y_o == '0)
    else $error("failure with nonzero position");

  // one request in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // with the output empty, a transfer does not bring its result straight away
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind shelf_rectangle_packer srp_checker u_srp_checker (.*);

`default_nettype wire

// ===== sim/tb_shelf_rectangle_packer.sv =====
`timescale 1ns / 100ps
// Testbench for shelf_rectangle_packer: directed and random rectangle requests, each
// placement checked against a first-fit shelf packing predictor kept in the bench.
// Depends on srp_pkg and the shelf_rectangle_packer RTL.

module tb_shelf_rectangle_packer;
  import srp_pkg::*;

  localparam int unsigned SHELVES      = MAX_SHELVES_DEF;
  localparam int unsigned CYCLE_LIMIT  = 800_000;
  localparam int unsigned DRAIN_CYCLES = SHELVES + 16;

  typedef struct {
    status_e       status;
    logic [XW-1:0] x;
    logic [HW-1:0] y;
  } place_t;

  logic          clk        = 1'b0;
  logic          rst_n      = 1'b0;
  logic          in_valid   = 1'b0;
  logic          in_ready;
  logic [WW-1:0] req_width  = '0;
  logic [HW-1:0] req_height = '0;
  logic          out_valid;
  logic          out_ready  = 1'b0;
  logic [1:0]    status;
  logic [XW-1:0] place_x;
  logic [HW-1:0] place_y;
  logic          cfg_we     = 1'b0;
  logic          cfg_idx    = REG_ATLAS_WIDTH;
  logic [HW-1:0] cfg_wdata  = '0;

  // predictor state
  int unsigned atlas_w = ATLAS_WIDTH_RST;
  int unsigned atlas_h = ATLAS_HEIGHT_RST;
  int unsigned shelf_top  [SHELVES];
  int unsigned shelf_fill [SHELVES];
  int unsigned shelf_ht   [SHELVES];
  int unsigned shelf_total = 0;

  place_t      pending_places[$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  bit          calm       = 1'b0;

  shelf_rectangle_packer u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .req_width_i  (req_width),
    .req_height_i (req_height),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .status_o     (status),
    .place_x_o    (place_x),
    .place_y_o    (place_y),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic int unsigned shelf_bottom();
    if (shelf_total == 0) return 0;
    return shelf_top[shelf_total-1] + shelf_ht[shelf_total-1];
  endfunction

  function automatic place_t place_rect(int unsigned w, int unsigned h);
    place_t      res;
    int unsigned i, room, new_y;
    res = '{ST_NO_ROOM, '0, '0};
    if (w > atlas_w || h > atlas_h) return res;
    for (i = 0; i < shelf_total; i++) begin
      room = shelf_fill[i] > atlas_w ? 0 : atlas_w - shelf_fill[i];
      if (room < w) continue;
      if (shelf_ht[i] < h) begin
        if (i + 1 != shelf_total) continue;
        if (shelf_top[i] > atlas_h || atlas_h - shelf_top[i] < h) continue;
        shelf_ht[i] = h;
      end
      res = '{ST_PLACED, XW'(shelf_fill[i]), HW'(shelf_top[i])};
      shelf_fill[i] = (shelf_fill[i] + w) & 32'h1FFF;
      return res;
    end
    if (shelf_total >= SHELVES) begin
      res.status = ST_TABLE_FULL;
      return res;
    end
    new_y = shelf_bottom();
    if (new_y > atlas_h || h > atlas_h - new_y) return res;
    shelf_top[shelf_total]  = new_y;
    shelf_fill[shelf_total] = w;
    shelf_ht[shelf_total]   = h;
    shelf_total++;
    res = '{ST_PLACED, '0, HW'(new_y)};
    return res;
  endfunction

  task automatic send_rect(int unsigned w, int unsigned h);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 29) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    req_width  = WW'(w);
    req_height = HW'(h);
    do @(posedge clk); while (!in_ready);
    pending_places.push_back(place_rect(w, h));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_places.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int unsigned value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = HW'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_ATLAS_WIDTH) atlas_w = value & 32'h1FFF;
    else atlas_h = value & 32'hFFFF;
  endtask

  task automatic set_atlas(int unsigned aw, int unsigned ah);
    wait_idle();
    write_reg(REG_ATLAS_WIDTH, aw);
    write_reg(REG_ATLAS_HEIGHT, ah);
  endtask

  // reset geometry: 1024 wide, zero height, so only zero-height rectangles fit
  task automatic test_reset_state();
    send_rect(0, 0);
    send_rect(1024, 0);
    send_rect(1025, 0);
    send_rect(0, 1);
  endtask

  task automatic test_oversize();
    set_atlas(1024, 100);
    send_rect(4096, 0);
    send_rect(10, 101);
    send_rect(0, 65535);
    send_rect(1024, 100);
  endtask

  // widest atlas: full shelves, x position wrapping past 4095, last shelf growth
  task automatic test_full_range();
    set_atlas(4096, 65535);
    send_rect(4096, 1);
    send_rect(3072, 0);
    send_rect(3072, 100);
    send_rect(0, 0);
    send_rect(0, 900);
    send_rect(1, 1);
  endtask

  task automatic test_shrunk_width();
    set_atlas(512, 65535);
    send_rect(10, 0);
    send_rect(600, 0);
    send_rect(511, 1);
  endtask

  task automatic test_shrunk_height();
    set_atlas(512, 200);
    send_rect(0, 5);
    send_rect(0, 0);
    set_atlas(512, 0);
    send_rect(5, 0);
    send_rect(0, 1);
  endtask

  task automatic test_random_phase(int unsigned phase, int unsigned count);
    int unsigned w, h, roll, hmax, bottom, aw, ah, n;
    bottom = shelf_bottom();
    case (phase % 4)
      0:       aw = $urandom_range(16, 160);
      1:       aw = 4096;
      2:       aw = $urandom_range(1, 4096);
      default: aw = 1;
    endcase
    if (phase == 5) ah = bottom > 0 ? $urandom_range(0, bottom - 1) : 0;
    else if (phase % 4 == 3) ah = 65535;
    else begin
      ah = bottom + $urandom_range(64, 3000);
      if (ah > 65535) ah = 65535;
    end
    set_atlas(aw, ah);
    calm = (phase == 1);
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        // noise: mostly oversize requests
        if (atlas_w < 4096) begin
          w = $urandom_range(atlas_w + 1, 4096);
          h = $urandom_range(0, 65535);
        end else if (atlas_h < 65535) begin
          w = $urandom_range(0, 4096);
          h = $urandom_range(atlas_h + 1, 65535);
        end else begin
          w = $urandom_range(0, 4096);
          h = $urandom_range(0, 65535);
        end
      end else begin
        w = $urandom_range(0, 99) < 70 ? $urandom_range(0, (atlas_w + 3) / 4)
                                        : $urandom_range(0, atlas_w);
        roll = $urandom_range(0, 99);
        hmax = roll < 75 ? 24 : (roll < 97 ? 255 : atlas_h);
        if (hmax > atlas_h) hmax = atlas_h;
        h = $urandom_range(0, hmax);
      end
      send_rect(w, h);
    end
    calm = 1'b0;
  endtask

  // zero-height full-width rectangles open shelves until the table is full
  task automatic test_table_full();
    set_atlas(4096, 65535);
    while (shelf_total < SHELVES) send_rect(4096, 0);
    send_rect(4096, $urandom_range(0, 8));
    send_rect(4096, 0);
    send_rect(0, 65535);
  endtask

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 29);
  end

  function automatic void note_mismatch(place_t want, bit orphan);
    mismatches++;
    if (mismatches <= 10) begin
      if (orphan)
        $display("unexpected transfer: status %0d x %0d y %0d", status, place_x, place_y);
      else
        $display("mismatch: expected status %0d x %0d y %0d, got status %0d x %0d y %0d",
                 want.status, want.x, want.y, status, place_x, place_y);
    end
  endfunction

  always @(posedge clk) begin : check_places
    place_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_places.size() == 0) begin
        want = '{ST_PLACED, '0, '0};
        note_mismatch(want, 1'b1);
      end else begin
        want = pending_places.pop_front();
        if (status !== want.status || place_x !== want.x || place_y !== want.y)
          note_mismatch(want, 1'b0);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[shelf_rectangle_packer] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned p;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_reset_state();
    test_oversize();
    test_full_range();
    test_shrunk_width();
    test_shrunk_height();
    for (p = 0; p < 6; p++) test_random_phase(p, 120);
    test_table_full();
    for (p = 6; p < 8; p++) test_random_phase(p, 120);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_places.size() == 0) begin
      $display("[shelf_rectangle_packer] OK");
    end else begin
      $display("[shelf_rectangle_packer] ERROR");
    end
    $finish;
  end

endmodule
